// File: sv/pmfb_pkg.sv
// Package for the paged monochrome framebuffer blitter.
// Holds screen geometry, command codes, channel payloads and controller links.
// No dependencies.
`default_nettype none

package pmfb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_ROWS     = 8;
	localparam int PAGES         = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int FRAME_BYTES   = SCREEN_WIDTH * PAGES;
	localparam int ADDR_W        = $clog2(FRAME_BYTES);

	// Command codes
	localparam logic [2:0] OP_CLEAR     = 3'd0;
	localparam logic [2:0] OP_PIXEL     = 3'd1;
	localparam logic [2:0] OP_RECT      = 3'd2;
	localparam logic [2:0] OP_SPR_START = 3'd3;
	localparam logic [2:0] OP_SPR_BYTE  = 3'd4;
	localparam logic [2:0] OP_PUBLISH   = 3'd5;
	localparam logic [2:0] OP_READ      = 3'd6;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] corner_x;
		logic [7:0] corner_y;
		logic [7:0] sprite_width;
		logic [7:0] sprite_height;
		logic       draw_color;
		logic       skip_clear_bits;
		logic [7:0] pattern_byte;
		logic [9:0] read_address;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       sprite_complete;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic init_clr;
		logic clear_wr;
		logic rect_rd;
		logic rect_wr;
		logic spr_wr;
		logic copy_rd;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       rect_empty;
		logic       rect_last;
		logic       spr_active;
		logic       spr_stop;
		logic       sweep_last;
		logic       rsp_free;
	} ctl_sts_t;

	// Byte index of a column within a page
	function automatic logic [ADDR_W-1:0] byte_addr(logic [4:0] page, logic [7:0] col);
		return ADDR_W'(32'(page) * SCREEN_WIDTH + 32'(col));
	endfunction

endpackage

`default_nettype wire

// File: sv/pmfb_cmd_if.sv
// Command channel interface for the framebuffer blitter.
// Depends on pmfb_pkg for the payload type.
`default_nettype none

interface pmfb_cmd_if;
	logic             valid;
	logic             ready;
	pmfb_pkg::cmd_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pmfb_rsp_if.sv
// Response channel interface for the framebuffer blitter.
// Depends on pmfb_pkg for the payload type.
`default_nettype none

interface pmfb_rsp_if;
	logic             valid;
	logic             ready;
	pmfb_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pmfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pmfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/pmfb_ctrl.sv
// Controller state machine of the framebuffer blitter.
// Depends on pmfb_pkg; drives pmfb_datapath through ctl_cmd_t.
`default_nettype none

module pmfb_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire pmfb_pkg::ctl_sts_t sts,
	output pmfb_pkg::ctl_cmd_t   ctl
);
	import pmfb_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_RECT_RD,
		ST_RECT_WR,
		ST_SPR_RD,
		ST_SPR_WR,
		ST_COPY,
		ST_COPY_TAIL,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && sts.rsp_free;

	// Decode datapath commands from state
	always_comb begin
		ctl          = '0;
		ctl.accept   = in_ready && in_valid;
		ctl.init_clr = (state_q == ST_INIT);
		ctl.clear_wr = (state_q == ST_CLEAR);
		ctl.rect_rd  = (state_q == ST_RECT_RD);
		ctl.rect_wr  = (state_q == ST_RECT_WR);
		ctl.spr_wr   = (state_q == ST_SPR_WR);
		ctl.copy_rd  = (state_q == ST_COPY);
		ctl.finish   = (state_q == ST_FINISH);
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					case (sts.op)
						OP_CLEAR:    state_q <= ST_CLEAR;
						OP_PIXEL,
						OP_RECT:     state_q <= sts.rect_empty ? ST_FINISH : ST_RECT_RD;
						OP_SPR_BYTE: state_q <= sts.spr_active ? ST_SPR_RD : ST_FINISH;
						OP_PUBLISH:  state_q <= ST_COPY;
						OP_READ:     state_q <= ST_READ;
						default:     state_q <= ST_FINISH;
					endcase
				end
				ST_CLEAR: begin
					if (sts.sweep_last) state_q <= ST_FINISH;
				end
				ST_RECT_RD: state_q <= ST_RECT_WR;
				ST_RECT_WR: begin
					state_q <= sts.rect_last ? ST_FINISH : ST_RECT_RD;
				end
				ST_SPR_RD: state_q <= ST_SPR_WR;
				ST_SPR_WR: begin
					state_q <= sts.spr_stop ? ST_FINISH : ST_SPR_RD;
				end
				ST_COPY: begin
					if (sts.sweep_last) state_q <= ST_COPY_TAIL;
				end
				ST_COPY_TAIL: state_q <= ST_FINISH;
				ST_READ:      state_q <= ST_FINISH;
				ST_FINISH:    state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/pmfb_datapath.sv
// Datapath of the framebuffer blitter: frame memories, rectangle and sprite
// walkers, sweep counter and response register. Depends on pmfb_pkg,
// pmfb_ram and pmfb_rsp_if.
`default_nettype none

module pmfb_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire pmfb_pkg::cmd_t  in_data,
	input  wire pmfb_pkg::ctl_cmd_t ctl,
	output pmfb_pkg::ctl_sts_t   sts,
	pmfb_rsp_if.source           rsp
);
	import pmfb_pkg::*;

	cmd_t              cmd_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] copy_addr_s1;

	// Rectangle walker
	logic [7:0] x0_q, bx_q, y0_q, by_q, col_q;
	logic [4:0] page_q;
	logic       rect_empty_q;

	// Sprite state
	logic [7:0] spr_origin_q;
	logic [8:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic       spr_color_q, spr_transp_q, spr_active_q;
	logic [2:0] bit_q;

	// Response register
	logic       rsp_valid_q;
	logic [7:0] rdata_q;
	logic       complete_q;

	logic [ADDR_W-1:0] rect_addr, spr_addr;
	logic [7:0]        rect_mask, spr_mask, back_rdata, front_rdata;
	logic [7:0]        rect_wdata, spr_wdata;
	logic [2:0]        lo, hi;
	logic              rect_last, spr_bit, spr_on, spr_draw, spr_color;
	logic [8:0]        nx, ny;
	logic              wrap, ending, sweep_last, rd_in_range;
	logic [7:0]        in_bx, in_by;
	logic              in_empty;
	logic              back_we, front_we;
	logic [ADDR_W-1:0] back_waddr, back_raddr, front_waddr;
	logic [7:0]        back_wdata, front_wdata;

	// Clip incoming rectangle; a pixel is a one-pixel rectangle
	always_comb begin
		if (in_data.operation == OP_PIXEL) begin
			in_bx    = in_data.pos_x;
			in_by    = in_data.pos_y;
			in_empty = 1'b0;
		end else begin
			in_bx    = ({1'b0, in_data.corner_x} > 9'(SCREEN_WIDTH - 1))
				? 8'(SCREEN_WIDTH - 1) : in_data.corner_x;
			in_by    = ({1'b0, in_data.corner_y} > 9'(SCREEN_HEIGHT - 1))
				? 8'(SCREEN_HEIGHT - 1) : in_data.corner_y;
			in_empty = (in_data.pos_x > in_data.corner_x)
				|| (in_data.pos_y > in_data.corner_y);
		end
		in_empty = in_empty || ({1'b0, in_data.pos_x} >= 9'(SCREEN_WIDTH))
			|| ({1'b0, in_data.pos_y} >= 9'(SCREEN_HEIGHT));
	end

	// Rectangle byte address and row mask within the current page
	always_comb begin
		rect_addr  = byte_addr(page_q, col_q);
		lo         = (page_q == y0_q[7:3]) ? y0_q[2:0] : 3'd0;
		hi         = (page_q == by_q[7:3]) ? by_q[2:0] : 3'd7;
		rect_mask  = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
		rect_wdata = cmd_q.draw_color ? (back_rdata | rect_mask)
			: (back_rdata & ~rect_mask);
		rect_last  = (col_q == bx_q) && (page_q == by_q[7:3]);
	end

	// Sprite pixel at the cursor
	always_comb begin
		spr_addr  = byte_addr(cur_y_q[7:3], cur_x_q[7:0]);
		spr_mask  = 8'(1) << cur_y_q[2:0];
		spr_bit   = cmd_q.pattern_byte[3'd7 - bit_q];
		spr_on    = (cur_x_q < 9'(SCREEN_WIDTH)) && (cur_y_q < 9'(SCREEN_HEIGHT));
		spr_draw  = spr_on && (spr_bit || !spr_transp_q);
		spr_color = spr_bit ? spr_color_q : !spr_color_q;
		spr_wdata = spr_color ? (back_rdata | spr_mask) : (back_rdata & ~spr_mask);
		nx        = cur_x_q + 9'd1;
		ny        = cur_y_q + 9'd1;
		wrap      = (nx >= end_x_q);
		ending    = wrap && (ny >= end_y_q);
	end

	assign sweep_last  = (cnt_q == ADDR_W'(FRAME_BYTES - 1));
	assign rd_in_range = (32'(cmd_q.read_address) < FRAME_BYTES);

	// Back frame ports
	always_comb begin
		back_we    = ctl.init_clr || ctl.clear_wr || ctl.rect_wr
			|| (ctl.spr_wr && spr_draw);
		back_waddr = (ctl.init_clr || ctl.clear_wr) ? cnt_q
			: (ctl.rect_wr ? rect_addr : spr_addr);
		back_wdata = (ctl.init_clr || ctl.clear_wr) ? 8'd0
			: (ctl.rect_wr ? rect_wdata : spr_wdata);
		back_raddr = ctl.copy_rd ? cnt_q : (ctl.rect_rd ? rect_addr : spr_addr);
	end

	// Front frame write port
	always_comb begin
		front_we    = ctl.init_clr || copy_v_s1;
		front_waddr = ctl.init_clr ? cnt_q : copy_addr_s1;
		front_wdata = ctl.init_clr ? 8'd0 : back_rdata;
	end

	pmfb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_back (
		.clk   (clk),
		.we    (back_we),
		.waddr (back_waddr),
		.wdata (back_wdata),
		.raddr (back_raddr),
		.rdata (back_rdata)
	);

	pmfb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_front (
		.clk   (clk),
		.we    (front_we),
		.waddr (front_waddr),
		.wdata (front_wdata),
		.raddr (ADDR_W'(cmd_q.read_address)),
		.rdata (front_rdata)
	);

	// Latch command and set up walkers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= in_data;
			x0_q   <= in_data.pos_x;
			y0_q   <= in_data.pos_y;
			bx_q   <= in_bx;
			by_q   <= in_by;
			col_q  <= in_data.pos_x;
			page_q <= in_data.pos_y[7:3];
		end else if (ctl.rect_wr) begin
			if (col_q == bx_q) begin
				col_q  <= x0_q;
				page_q <= page_q + 5'd1;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
		copy_addr_s1 <= cnt_q;
	end

	// Control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			copy_v_s1    <= 1'b0;
			rect_empty_q <= 1'b0;
			bit_q        <= 3'd0;
		end else begin
			copy_v_s1 <= ctl.copy_rd;
			if (ctl.accept) begin
				cnt_q        <= '0;
				rect_empty_q <= in_empty;
				bit_q        <= 3'd0;
			end else begin
				if (ctl.init_clr || ctl.clear_wr || ctl.copy_rd) cnt_q <= cnt_q + 1'b1;
				if (ctl.spr_wr) bit_q <= bit_q + 3'd1;
			end
		end
	end

	// Sprite start and cursor advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_origin_q <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			spr_color_q  <= 1'b0;
			spr_transp_q <= 1'b0;
			spr_active_q <= 1'b0;
		end else if (ctl.accept && in_data.operation == OP_SPR_START) begin
			spr_origin_q <= in_data.pos_x;
			cur_x_q      <= {1'b0, in_data.pos_x};
			cur_y_q      <= {1'b0, in_data.pos_y};
			end_x_q      <= {1'b0, in_data.pos_x} + {1'b0, in_data.sprite_width};
			end_y_q      <= {1'b0, in_data.pos_y} + {1'b0, in_data.sprite_height};
			spr_color_q  <= in_data.draw_color;
			spr_transp_q <= in_data.skip_clear_bits;
			spr_active_q <= (in_data.sprite_width != 8'd0) && (in_data.sprite_height != 8'd0);
		end else if (ctl.spr_wr) begin
			if (wrap) begin
				cur_x_q <= {1'b0, spr_origin_q};
				cur_y_q <= ny;
				if (ending) spr_active_q <= 1'b0;
			end else begin
				cur_x_q <= nx;
			end
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rdata_q    <= (cmd_q.operation == OP_READ && rd_in_range) ? front_rdata : 8'd0;
			complete_q <= !spr_active_q;
		end
	end

	assign rsp.valid                = rsp_valid_q;
	assign rsp.data.read_data       = rdata_q;
	assign rsp.data.sprite_complete = complete_q;

	always_comb begin
		sts            = '0;
		sts.op         = cmd_q.operation;
		sts.rect_empty = rect_empty_q;
		sts.rect_last  = rect_last;
		sts.spr_active = spr_active_q;
		sts.spr_stop   = (bit_q == 3'd7) || ending;
		sts.sweep_last = sweep_last;
		sts.rsp_free   = !rsp_valid_q || rsp.ready;
	end

endmodule

`default_nettype wire

// File: sv/paged_mono_framebuffer_blitter.sv
// Paged monochrome framebuffer blitter, top level.
// Channels: cmd (sink) takes one drawing command per transaction; rsp
// (source) returns exactly one result per command, in order.
// The frame is stored as 8-row pages, one byte per column per page, in a
// back and a front memory of FRAME_BYTES (1024) bytes each.
// Work per command: a pixel or rectangle is a read then a write per touched
// byte (page column); a sprite byte walks at most 8 pixels, each a read then a
// write; clear sweeps the back frame and publish copies it to the front, one
// byte a cycle; a read takes one byte from the front frame.
// Each frame memory has a single read/write port pair, so every drawn byte
// is a read then a write.
// A new command is accepted once the engine is idle and the result slot is
// free or being taken in the same cycle; a stalled receiver holds the result
// and blocks further commands.
// After reset both frames are cleared by a sweep of all FRAME_BYTES (1024)
// addresses, during which no command is accepted; sprite state resets to none.
`default_nettype none

module paged_mono_framebuffer_blitter (
	input  wire         clk,
	input  wire         arst_n,
	pmfb_cmd_if.sink    cmd,
	pmfb_rsp_if.source  rsp
);
	import pmfb_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;
	logic     ready;

	assign cmd.ready = ready;

	pmfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pmfb_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (cmd.data),
		.ctl     (ctl),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// File: sim/tb_paged_mono_framebuffer_blitter.sv
// Testbench for the paged monochrome framebuffer blitter.
// Drives drawing commands, predicts each result from a local frame model and checks it.
// Depends on pmfb_pkg, pmfb_cmd_if, pmfb_rsp_if and the blitter RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_paged_mono_framebuffer_blitter;
	import pmfb_pkg::*;

	// Unassigned command code, ignored by the blitter
	localparam logic [2:0] OP_INVALID = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   mismatch_count;
	bit   idle_enable;

	pmfb_cmd_if cmd ();
	pmfb_rsp_if rsp ();

	paged_mono_framebuffer_blitter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow state of the blitter
	logic [7:0] back_mem [FRAME_BYTES];
	logic [7:0] front_mem [FRAME_BYTES];
	logic [7:0] spr_origin_x;
	logic [8:0] spr_cur_x, spr_cur_y, spr_end_x, spr_end_y;
	logic       spr_color, spr_transp, spr_active;
	rsp_t       pending_rsp [$];

	function automatic void plot(int x, int y, logic color);
		int idx;
		if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
			return;
		idx = (y / PAGE_ROWS) * SCREEN_WIDTH + x;
		back_mem[idx][y % PAGE_ROWS] = color;
	endfunction

	// Apply one command to the shadow state and return the expected result
	function automatic rsp_t apply_command(cmd_t c);
		rsp_t r;
		int   bx, by;
		r = '0;
		case (c.operation)
			OP_CLEAR: begin
				foreach (back_mem[i]) back_mem[i] = '0;
			end
			OP_PIXEL: plot(c.pos_x, c.pos_y, c.draw_color);
			OP_RECT: begin
				if (c.pos_x <= c.corner_x && c.pos_y <= c.corner_y) begin
					bx = (c.corner_x >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : c.corner_x;
					by = (c.corner_y >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : c.corner_y;
					for (int y = c.pos_y; y <= by; y++)
						for (int x = c.pos_x; x <= bx; x++)
							plot(x, y, c.draw_color);
				end
			end
			OP_SPR_START: begin
				spr_origin_x = c.pos_x;
				spr_cur_x    = {1'b0, c.pos_x};
				spr_cur_y    = {1'b0, c.pos_y};
				spr_end_x    = c.pos_x + c.sprite_width;
				spr_end_y    = c.pos_y + c.sprite_height;
				spr_color    = c.draw_color;
				spr_transp   = c.skip_clear_bits;
				spr_active   = (c.sprite_width != 0 && c.sprite_height != 0);
			end
			OP_SPR_BYTE: begin
				for (int b = 7; b >= 0 && spr_active; b--) begin
					if (c.pattern_byte[b])
						plot(spr_cur_x, spr_cur_y, spr_color);
					else if (!spr_transp)
						plot(spr_cur_x, spr_cur_y, !spr_color);
					spr_cur_x++;
					if (spr_cur_x >= spr_end_x) begin
						spr_cur_x = {1'b0, spr_origin_x};
						spr_cur_y++;
						if (spr_cur_y >= spr_end_y)
							spr_active = 1'b0;
					end
				end
			end
			OP_PUBLISH: front_mem = back_mem;
			OP_READ: begin
				if (c.read_address < FRAME_BYTES)
					r.read_data = front_mem[c.read_address];
			end
			default: ;
		endcase
		r.sprite_complete = !spr_active;
		return r;
	endfunction

	// Send one command, predicting its result when accepted; valid drops only when idling
	task automatic send_command(cmd_t c);
		while (idle_enable && $urandom_range(99) < 34) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= c;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		pending_rsp.push_back(apply_command(c));
		@(negedge clk);
	endtask

	function automatic cmd_t random_fields();
		cmd_t c;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom}));
		return c;
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] op, int px, int py, int cx, int cy);
		cmd_t c;
		c = random_fields();
		c.operation = op;
		c.pos_x = 8'(px);
		c.pos_y = 8'(py);
		c.corner_x = 8'(cx);
		c.corner_y = 8'(cy);
		return c;
	endfunction

	// Receiver stalls at random when idling is enabled; check every transaction against the oldest prediction
	always @(negedge clk) begin
		rsp.ready <= !(idle_enable && $urandom_range(99) < 34);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (mismatch_count++ < 10)
					$display("unexpected result %h", rsp.data);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.data.read_data !== want.read_data ||
						rsp.data.sprite_complete !== want.sprite_complete) begin
					fail_count++;
					if (mismatch_count++ < 10)
						$display("mismatch: expected data %h done %b, got data %h done %b",
							want.read_data, want.sprite_complete,
							rsp.data.read_data, rsp.data.sprite_complete);
				end
			end
		end
	end

	// Drop valid and hold until every expected result has come
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic read_all_front();
		cmd_t c;
		for (int a = 0; a < FRAME_BYTES; a += 37) begin
			c = make_cmd(OP_READ, 0, 0, 0, 0);
			c.read_address = 10'(a);
			send_command(c);
		end
	endtask

	// Extremes, every operation and the special cases
	task automatic test_directed();
		cmd_t c;
		send_command(make_cmd(OP_RECT, 0, 0, 255, 255));
		c = make_cmd(OP_PIXEL, 127, 63, 0, 0); c.draw_color = 1'b0; send_command(c);
		send_command(make_cmd(OP_PIXEL, 128, 64, 0, 0));
		send_command(make_cmd(OP_RECT, 10, 5, 3, 9));
		c = make_cmd(OP_SPR_START, 120, 60, 0, 0);
		c.sprite_width = 12; c.sprite_height = 6; c.skip_clear_bits = 0;
		send_command(c);
		for (int i = 0; i < 10; i++) begin
			c = make_cmd(OP_SPR_BYTE, 0, 0, 0, 0); send_command(c);
		end
		c = make_cmd(OP_SPR_START, 255, 255, 0, 0);
		c.sprite_width = 255; c.sprite_height = 1; send_command(c);
		c = make_cmd(OP_SPR_START, 5, 5, 0, 0); c.sprite_width = 0; send_command(c);
		send_command(make_cmd(OP_SPR_BYTE, 0, 0, 0, 0));
		send_command(make_cmd(OP_PUBLISH, 0, 0, 0, 0));
		c = make_cmd(OP_READ, 0, 0, 0, 0); c.read_address = 1023; send_command(c);
		send_command(make_cmd(OP_INVALID, 0, 0, 0, 0));
		read_all_front();
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 0));
	endtask

	// Mostly well-formed sprite streams and small drawings, with random noise
	task automatic test_random(int count);
		cmd_t c;
		int   n;
		n = 0;
		while (n < count) begin
			c = random_fields();
			case ($urandom_range(9))
				0, 1: begin
					c.operation = OP_SPR_START;
					c.pos_x = 8'($urandom_range(140));
					c.pos_y = 8'($urandom_range(70));
					c.sprite_width = 8'($urandom_range(16));
					c.sprite_height = 8'($urandom_range(12));
					send_command(c);
					n++;
					repeat ($urandom_range(20)) begin
						c = random_fields();
						c.operation = OP_SPR_BYTE;
						send_command(c);
						n++;
					end
				end
				2: begin
					c.operation = OP_RECT;
					c.pos_x = 8'($urandom_range(130)); c.pos_y = 8'($urandom_range(66));
					c.corner_x = c.pos_x + 8'($urandom_range(12));
					c.corner_y = c.pos_y + 8'($urandom_range(10));
					if ($urandom_range(9) == 0) c = make_cmd(OP_RECT, $urandom, $urandom,
						$urandom, $urandom);
					send_command(c); n++;
				end
				3, 4: begin
					c.operation = OP_PIXEL;
					if ($urandom_range(3) != 0) begin
						c.pos_x = 8'($urandom_range(127)); c.pos_y = 8'($urandom_range(63));
					end
					send_command(c); n++;
				end
				5, 6: begin
					c.operation = ($urandom_range(3) == 0) ? OP_INVALID : OP_READ;
					send_command(c); n++;
				end
				7: begin
					c.operation = ($urandom_range(7) == 0) ? OP_CLEAR : OP_PUBLISH;
					send_command(c); n++;
				end
				default: begin
					send_command(c); n++;
				end
			endcase
		end
	endtask

	initial begin
		fail_count = 0;
		mismatch_count = 0;
		idle_enable = 1'b0;
		cmd.valid = 1'b0;
		cmd.data = '0;
		rsp.ready = 1'b0;
		foreach (back_mem[i]) back_mem[i] = '0;
		foreach (front_mem[i]) front_mem[i] = '0;
		spr_origin_x = '0;
		{spr_cur_x, spr_cur_y, spr_end_x, spr_end_y} = '0;
		{spr_color, spr_transp, spr_active} = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No idling in the directed part
		test_directed();
		wait_drained();
		idle_enable = 1'b1;
		test_random(700);
		// Hold the sender until the result queue empties
		wait_drained();
		test_random(700);
		send_command(make_cmd(OP_PUBLISH, 0, 0, 0, 0));
		read_all_front();
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
sv/pmfb_pkg.sv
sv/pmfb_cmd_if.sv
sv/pmfb_rsp_if.sv
sv/pmfb_ram.sv
sv/pmfb_ctrl.sv
sv/pmfb_datapath.sv
sv/paged_mono_framebuffer_blitter.sv
sim/tb_paged_mono_framebuffer_blitter.sv
